FILE: src/phcft_pkg.sv
package phcft_pkg;

	localparam int MaxHosts = 64;
	localparam int MaxConns = 256;
	localparam int HostIdxW = $clog2(MaxHosts);
	localparam int ConnIdxW = $clog2(MaxConns);
	localparam int HostCntW = $clog2(MaxHosts + 1);
	localparam int ConnCntW = $clog2(MaxConns + 1);

	localparam logic [7:0] ProtoIcmp = 8'd1;
	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;
	localparam logic [1:0] StatusReset = 2'd3;

	localparam logic [0:0] CfgLocalAddr = 1'b0;
	localparam logic [0:0] CfgFinsToClose = 1'b1;
	localparam int CfgIdxW = 1;

	localparam logic [47:0] BytesMax = {48{1'b1}};
	localparam logic [31:0] PktsMax = {32{1'b1}};

	// Search key sent down the host chain.
	typedef struct packed {
		logic [31:0] remote;
	} host_probe_t;

	// Search key sent down the connection chain.
	typedef struct packed {
		logic [HostIdxW-1:0] host;
		logic [7:0] proto;
		logic [15:0] key;
		logic [1:0] fins_to_close;
	} conn_probe_t;

	// One stored connection record.
	typedef struct packed {
		logic [HostIdxW-1:0] host;
		logic [7:0] proto;
		logic [15:0] key;
		logic [1:0] status;
		logic [31:0] first;
		logic [31:0] last;
		logic [47:0] bytes_in;
		logic [47:0] bytes_out;
		logic [31:0] pkts_in;
		logic [31:0] pkts_out;
	} conn_rec_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0] ip_protocol;
		logic [15:0] total_length;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0] icmp_type;
		logic fin_flag;
		logic rst_flag;
		logic [31:0] timestamp;
	} req_t;

	typedef struct packed {
		logic [5:0] host_index;
		logic [7:0] conn_index;
		logic new_host;
		logic new_conn;
		logic dropped;
		logic [1:0] conn_state;
		logic [47:0] in_bytes;
		logic [47:0] out_bytes;
		logic [31:0] in_packets;
		logic [31:0] out_packets;
		logic [31:0] first_seen;
	} rsp_t;

endpackage

FILE: src/phcft_req_if.sv
interface phcft_req_if;
	logic valid;
	logic ready;
	phcft_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/phcft_rsp_if.sv
interface phcft_rsp_if;
	logic valid;
	logic ready;
	phcft_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: src/phcft_host_cell.sv
// One host slot. The probe and a hit flag pass through it each cycle.
module phcft_host_cell (
	input logic clk,
	input logic arst_n,
	input logic [phcft_pkg::HostIdxW-1:0] slot,
	input logic used,
	input logic wr_en,
	input logic [31:0] wr_addr,
	input logic go_in,
	input phcft_pkg::host_probe_t probe_in,
	input logic hit_in,
	input logic [phcft_pkg::HostIdxW-1:0] idx_in,
	output logic go_out,
	output phcft_pkg::host_probe_t probe_out,
	output logic hit_out,
	output logic [phcft_pkg::HostIdxW-1:0] idx_out
);
	logic [31:0] addr_q;
	logic match;

	// Stored address.
	always_ff @(posedge clk) begin
		if (wr_en) addr_q <= wr_addr;
	end

	assign match = used && !hit_in && (addr_q == probe_in.remote);

	// Hand the probe on to the next slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_out <= 1'b0;
		end else begin
			go_out <= go_in;
		end
	end

	always_ff @(posedge clk) begin
		probe_out <= probe_in;
		hit_out <= hit_in | match;
		idx_out <= match ? slot : idx_in;
	end
endmodule

FILE: src/phcft_conn_cell.sv
// One connection slot. It matches the probe and carries the first hit on.
module phcft_conn_cell (
	input logic clk,
	input logic arst_n,
	input logic [phcft_pkg::ConnIdxW-1:0] slot,
	input logic used,
	input logic wr_en,
	input phcft_pkg::conn_rec_t wr_rec,
	input logic go_in,
	input phcft_pkg::conn_probe_t probe_in,
	input logic hit_in,
	input logic [phcft_pkg::ConnIdxW-1:0] idx_in,
	input phcft_pkg::conn_rec_t rec_in,
	output logic go_out,
	output phcft_pkg::conn_probe_t probe_out,
	output logic hit_out,
	output logic [phcft_pkg::ConnIdxW-1:0] idx_out,
	output phcft_pkg::conn_rec_t rec_out
);
	phcft_pkg::conn_rec_t rec_q;
	logic match;
	logic key_ok;

	always_ff @(posedge clk) begin
		if (wr_en) rec_q <= wr_rec;
	end

	// Protocol specific match rule.
	always_comb begin
		key_ok = 1'b1;
		if (probe_in.proto == phcft_pkg::ProtoTcp) begin
			key_ok = (rec_q.key == probe_in.key) &&
				(rec_q.status != probe_in.fins_to_close) &&
				(rec_q.status != phcft_pkg::StatusReset);
		end else if (probe_in.proto == phcft_pkg::ProtoUdp ||
				probe_in.proto == phcft_pkg::ProtoIcmp) begin
			key_ok = (rec_q.key == probe_in.key);
		end
	end

	assign match = used && !hit_in && (rec_q.host == probe_in.host) &&
		(rec_q.proto == probe_in.proto) && key_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_out <= 1'b0;
		end else begin
			go_out <= go_in;
		end
	end

	always_ff @(posedge clk) begin
		probe_out <= probe_in;
		hit_out <= hit_in | match;
		idx_out <= match ? slot : idx_in;
		rec_out <= match ? rec_q : rec_in;
	end
endmodule

FILE: src/per_host_connection_flow_table_top.sv
// Per-host connection flow table.
// Channel req carries one packet header per request; channel rsp returns
// one result per request, in order. Configuration goes through a plain
// write port (cfg_we, cfg_idx, cfg_wdata): index 0 local address,
// index 1 FIN count at which a TCP connection is closed.
// One request at a time: the host lookup runs down a chain of 64 host
// cells (one cell per cycle). If the host is known, the connection lookup
// then runs down a chain of 256 connection cells; then the update state
// writes the tables and the result register.
// The result sits in an output register until the receiver takes it;
// the next request is accepted in the cycle after that result has been taken.
// Reset empties both tables (counts go to zero), sets the local address
// to 0 and the closing FIN count to 2. A stalled receiver only holds the
// result register and blocks the input; nothing is lost.
module per_host_connection_flow_table_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [phcft_pkg::CfgIdxW-1:0] cfg_idx,
	input logic [31:0] cfg_wdata,
	phcft_req_if.sink req,
	phcft_rsp_if.source rsp
);
	localparam int NH = phcft_pkg::MaxHosts;
	localparam int NC = phcft_pkg::MaxConns;
	localparam int HW = phcft_pkg::HostIdxW;
	localparam int CW = phcft_pkg::ConnIdxW;

	typedef enum logic [4:0] {
		StIdle = 5'b00001,
		StHost = 5'b00010,
		StConn = 5'b00100,
		StUpd = 5'b01000,
		StOut = 5'b10000
	} state_t;

	state_t state_q;
	logic [31:0] local_addr_q;
	logic [1:0] fins_q;
	logic [phcft_pkg::HostCntW-1:0] host_cnt_q;
	logic [phcft_pkg::ConnCntW-1:0] conn_cnt_q;
	phcft_pkg::req_t pkt_q;
	logic inbound_q;
	logic [15:0] key_q;
	logic host_hit_q;
	logic [HW-1:0] host_idx_q;
	phcft_pkg::rsp_t rsp_q;

	// Chain wiring.
	logic hgo [NH+1];
	phcft_pkg::host_probe_t hprobe [NH+1];
	logic hhit [NH+1];
	logic [HW-1:0] hidx [NH+1];
	logic cgo [NC+1];
	phcft_pkg::conn_probe_t cprobe [NC+1];
	logic chit [NC+1];
	logic [CW-1:0] cidx [NC+1];
	phcft_pkg::conn_rec_t crec [NC+1];

	logic host_wr;
	logic conn_wr;
	logic [CW-1:0] conn_wr_idx;
	phcft_pkg::conn_rec_t conn_wr_rec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			fins_q <= 2'd2;
		end else if (cfg_we) begin
			case (cfg_idx)
				phcft_pkg::CfgLocalAddr: local_addr_q <= cfg_wdata;
				phcft_pkg::CfgFinsToClose: fins_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == StIdle);
	assign rsp.valid = (state_q == StOut);
	assign rsp.data = rsp_q;

	// Host chain head.
	assign hgo[0] = (state_q == StIdle) && req.valid;
	assign hprobe[0].remote = (req.data.dst_addr == local_addr_q) ?
		req.data.src_addr : req.data.dst_addr;
	assign hhit[0] = 1'b0;
	assign hidx[0] = '0;

	for (genvar g = 0; g < NH; g++) begin : g_host
		phcft_host_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.slot(HW'(g)),
			.used(host_cnt_q > phcft_pkg::HostCntW'(g)),
			.wr_en(host_wr && host_cnt_q[HW-1:0] == HW'(g)),
			.wr_addr(inbound_q ? pkt_q.src_addr : pkt_q.dst_addr),
			.go_in(hgo[g]), .probe_in(hprobe[g]), .hit_in(hhit[g]),
			.idx_in(hidx[g]),
			.go_out(hgo[g+1]), .probe_out(hprobe[g+1]), .hit_out(hhit[g+1]),
			.idx_out(hidx[g+1])
		);
	end

	// Connection chain head, started when the host chain finishes with a hit.
	assign cgo[0] = hgo[NH] && hhit[NH];
	assign cprobe[0].host = hidx[NH];
	assign cprobe[0].proto = pkt_q.ip_protocol;
	assign cprobe[0].key = key_q;
	assign cprobe[0].fins_to_close = fins_q;
	assign chit[0] = 1'b0;
	assign cidx[0] = '0;
	assign crec[0] = '0;

	for (genvar g = 0; g < NC; g++) begin : g_conn
		phcft_conn_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.slot(CW'(g)),
			.used(conn_cnt_q > phcft_pkg::ConnCntW'(g)),
			.wr_en(conn_wr && conn_wr_idx == CW'(g)),
			.wr_rec(conn_wr_rec),
			.go_in(cgo[g]), .probe_in(cprobe[g]), .hit_in(chit[g]),
			.idx_in(cidx[g]), .rec_in(crec[g]),
			.go_out(cgo[g+1]), .probe_out(cprobe[g+1]), .hit_out(chit[g+1]),
			.idx_out(cidx[g+1]), .rec_out(crec[g+1])
		);
	end

	// Update computation.
	logic found_q;
	logic [CW-1:0] cidx_q;
	phcft_pkg::conn_rec_t crec_q;
	logic need_drop;
	logic is_tcp;
	logic counts_bytes;
	phcft_pkg::conn_rec_t upd;
	logic [48:0] bsum;
	logic [32:0] psum;
	phcft_pkg::rsp_t rsp_d;

	assign is_tcp = pkt_q.ip_protocol == phcft_pkg::ProtoTcp;
	assign counts_bytes = is_tcp || pkt_q.ip_protocol == phcft_pkg::ProtoUdp;
	assign need_drop = !found_q && ((!host_hit_q &&
		host_cnt_q >= phcft_pkg::HostCntW'(NH)) ||
		conn_cnt_q >= phcft_pkg::ConnCntW'(NC));

	always_comb begin
		upd = crec_q;
		bsum = '0;
		psum = '0;
		if (!found_q) begin
			upd.host = host_hit_q ? host_idx_q : host_cnt_q[HW-1:0];
			upd.proto = pkt_q.ip_protocol;
			upd.key = key_q;
			upd.status = '0;
			upd.first = pkt_q.timestamp;
			upd.last = pkt_q.timestamp;
			upd.bytes_in = inbound_q ? 48'(pkt_q.total_length) : '0;
			upd.bytes_out = inbound_q ? '0 : 48'(pkt_q.total_length);
			upd.pkts_in = inbound_q ? 32'd1 : 32'd0;
			upd.pkts_out = inbound_q ? 32'd0 : 32'd1;
		end else begin
			upd.last = pkt_q.timestamp;
			if (is_tcp) begin
				if (pkt_q.fin_flag) upd.status = crec_q.status + 2'd1;
				if (pkt_q.rst_flag) upd.status = phcft_pkg::StatusReset;
			end
			bsum = {1'b0, inbound_q ? crec_q.bytes_in : crec_q.bytes_out} +
				49'(pkt_q.total_length);
			psum = {1'b0, inbound_q ? crec_q.pkts_in : crec_q.pkts_out} + 33'd1;
			if (counts_bytes) begin
				if (inbound_q) upd.bytes_in = bsum[48] ? phcft_pkg::BytesMax : bsum[47:0];
				else upd.bytes_out = bsum[48] ? phcft_pkg::BytesMax : bsum[47:0];
			end
			if (inbound_q) upd.pkts_in = psum[32] ? phcft_pkg::PktsMax : psum[31:0];
			else upd.pkts_out = psum[32] ? phcft_pkg::PktsMax : psum[31:0];
		end
	end

	// Result assembled from the update; a dropped request reports zeros apart from the dropped flag.
	always_comb begin
		rsp_d = '0;
		rsp_d.dropped = need_drop;
		if (!need_drop) begin
			rsp_d.host_index = 6'(upd.host);
			rsp_d.conn_index = 8'(conn_wr_idx);
			rsp_d.new_host = !found_q && !host_hit_q;
			rsp_d.new_conn = !found_q;
			rsp_d.conn_state = upd.status;
			rsp_d.in_bytes = upd.bytes_in;
			rsp_d.out_bytes = upd.bytes_out;
			rsp_d.in_packets = upd.pkts_in;
			rsp_d.out_packets = upd.pkts_out;
			rsp_d.first_seen = upd.first;
		end
	end

	assign host_wr = (state_q == StUpd) && !need_drop && !found_q && !host_hit_q;
	assign conn_wr = (state_q == StUpd) && !need_drop;
	assign conn_wr_idx = found_q ? cidx_q : conn_cnt_q[CW-1:0];
	assign conn_wr_rec = upd;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			host_cnt_q <= '0;
			conn_cnt_q <= '0;
		end else begin
			case (state_q)
				StIdle: if (req.valid) state_q <= StHost;
				StHost: if (hgo[NH]) state_q <= hhit[NH] ? StConn : StUpd;
				StConn: if (cgo[NC]) state_q <= StUpd;
				StUpd: begin
					state_q <= StOut;
					if (host_wr) host_cnt_q <= host_cnt_q + 1'b1;
					if (conn_wr && !found_q) conn_cnt_q <= conn_cnt_q + 1'b1;
				end
				StOut: if (rsp.ready) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == StIdle && req.valid) begin
			pkt_q <= req.data;
			inbound_q <= req.data.dst_addr == local_addr_q;
			if (req.data.ip_protocol == phcft_pkg::ProtoIcmp)
				key_q <= {8'd0, req.data.icmp_type};
			else if (req.data.ip_protocol == phcft_pkg::ProtoTcp ||
					req.data.ip_protocol == phcft_pkg::ProtoUdp)
				key_q <= (req.data.dst_addr == local_addr_q) ?
					req.data.src_port : req.data.dst_port;
			else
				key_q <= '0;
		end
		if (state_q == StHost && hgo[NH]) begin
			host_hit_q <= hhit[NH];
			host_idx_q <= hidx[NH];
			found_q <= 1'b0;
		end
		if (state_q == StConn && cgo[NC]) begin
			found_q <= chit[NC];
			cidx_q <= cidx[NC];
			crec_q <= crec[NC];
		end
		if (state_q == StUpd) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		conn_cnt_q <= phcft_pkg::ConnCntW'(NC)) else $error("conn count overflow");
	a_host_le_conn: assert property (@(posedge clk) disable iff (!arst_n)
		phcft_pkg::ConnCntW'(host_cnt_q) <= conn_cnt_q)
		else $error("more hosts than connections");
	a_out_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StUpd |=> state_q == StOut) else $error("update not followed by result");
	a_one_go: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StIdle |-> !cgo[NC] && !hgo[NH]) else $error("stray probe in chain");
`endif
endmodule
